### sv/cljq_pkg.sv
// Package with shared constants and control types of the job queue.
package cljq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_TAG_BITS    = 16;
   localparam int RUN_W           = 8;
   localparam int KIND_W          = 2;

   localparam logic [RUN_W-1:0] MAX_WORKERS_RESET = 8'd4;
   localparam logic [RUN_W-1:0] RUN_LIMIT         = 8'd255;

   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
      logic dispatch;
   } dp_cmd_type;

   typedef struct packed {
      logic out_full;
   } dp_status_type;

endpackage

### sv/cljq_if.sv
// Handshake channel interfaces for event items, result items and configuration writes.
interface cljq_req_if #(parameter int TAG_BITS = 16);
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [TAG_BITS-1:0] job_tag;
   modport source (output valid, kind, job_tag, input ready);
   modport sink   (input valid, kind, job_tag, output ready);
endinterface

interface cljq_rsp_if #(parameter int TAG_BITS = 16, parameter int CNT_W = 5);
   logic                valid;
   logic                ready;
   logic                dispatch_valid;
   logic [TAG_BITS-1:0] dispatch_tag;
   logic                cancel_found;
   logic                push_dropped;
   logic                done_underflow;
   logic [CNT_W-1:0]    queued_count;
   logic [7:0]          running_count;
   modport source (output valid, dispatch_valid, dispatch_tag, cancel_found, push_dropped,
                   done_underflow, queued_count, running_count, input ready);
   modport sink   (input valid, dispatch_valid, dispatch_tag, cancel_found, push_dropped,
                   done_underflow, queued_count, running_count, output ready);
endinterface

interface cljq_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] max_workers;
   modport source (output valid, max_workers, input ready);
   modport sink   (input valid, max_workers, output ready);
endinterface

### sv/cljq_ctrl.sv
// Controller state machine sequencing accept, event execution and dispatch.
module cljq_ctrl
   import cljq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DISP} state_type;

   state_type state_ff;
   logic      disp_go;

   assign req_ready    = (state_ff == S_IDLE);
   assign disp_go      = (state_ff == S_DISP) && (!status.out_full || rsp_ready);
   assign cmd.load     = req_ready && req_valid;
   assign cmd.exec     = (state_ff == S_EXEC);
   assign cmd.dispatch = disp_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_EXEC;
            end
            S_EXEC: state_ff <= S_DISP;
            S_DISP: begin
               if (disp_go) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Only one item is in work, so no new item is taken before its result is registered.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec ##1 !req_ready)
      else $error("item accepted while another is in work");

   a_exec_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> $past(cmd.load))
      else $error("execution without an accepted item");

   a_dispatch_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.dispatch |-> (!status.out_full || rsp_ready))
      else $error("result written over one not yet taken");

endmodule

### sv/cljq_datapath.sv
// Datapath: shift-chain tag queue, running counter, limit register and result register.
module cljq_datapath
   import cljq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int TAG_BITS    = DEF_TAG_BITS,
   localparam int IDX_W      = $clog2(QUEUE_DEPTH),
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
)
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [TAG_BITS-1:0] req_tag,
   input  logic                csr_write,
   input  logic [RUN_W-1:0]    csr_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_dispatch_valid,
   output logic [TAG_BITS-1:0] rsp_dispatch_tag,
   output logic                rsp_cancel_found,
   output logic                rsp_push_dropped,
   output logic                rsp_done_underflow,
   output logic [CNT_W-1:0]    rsp_queued_count,
   output logic [RUN_W-1:0]    rsp_running_count
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   logic [TAG_BITS-1:0] cells_ff [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] cells_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [RUN_W-1:0]    running_ff, running_in;
   logic [RUN_W-1:0]    max_workers_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic                found_ff, found_in;
   logic                dropped_ff, dropped_in;
   logic                underflow_ff, underflow_in;
   logic                rsp_valid_ff;
   logic                disp_ok;

   logic                rsp_dispatch_valid_ff;
   logic [TAG_BITS-1:0] rsp_dispatch_tag_ff;
   logic                rsp_cancel_found_ff;
   logic                rsp_push_dropped_ff;
   logic                rsp_done_underflow_ff;
   logic [CNT_W-1:0]    rsp_queued_count_ff;
   logic [RUN_W-1:0]    rsp_running_count_ff;

   logic                match_any;
   logic [IDX_W-1:0]    match_pos;
   logic                remove_en;
   logic [IDX_W-1:0]    remove_pos;
   logic                push_en;

   // Youngest matching entry: later cells override earlier ones.
   always_comb begin
      match_any = 1'b0;
      match_pos = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if ((CNT_W'(i) < count_ff) && (cells_ff[i] == tag_ff)) begin
            match_any = 1'b1;
            match_pos = IDX_W'(i);
         end
      end
   end

   assign disp_ok = (count_ff != '0) && (running_ff < max_workers_ff) &&
                    (running_ff != RUN_LIMIT);

   always_comb begin
      count_in     = count_ff;
      running_in   = running_ff;
      found_in     = found_ff;
      dropped_in   = dropped_ff;
      underflow_in = underflow_ff;
      remove_en    = 1'b0;
      remove_pos   = '0;
      push_en      = 1'b0;
      if (cmd.exec) begin
         found_in     = 1'b0;
         dropped_in   = 1'b0;
         underflow_in = 1'b0;
         case (kind_ff)
            KIND_PUSH: begin
               if (count_ff >= DEPTH_CNT) begin
                  dropped_in = 1'b1;
               end else begin
                  push_en  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            KIND_DONE: begin
               if (running_ff == '0) underflow_in = 1'b1;
               else running_in = running_ff - 1'b1;
            end
            KIND_CANCEL: begin
               if (match_any) begin
                  found_in   = 1'b1;
                  remove_en  = 1'b1;
                  remove_pos = match_pos;
                  count_in   = count_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end else if (cmd.dispatch && disp_ok) begin
         remove_en  = 1'b1;
         count_in   = count_ff - 1'b1;
         running_in = running_ff + 1'b1;
      end
   end

   // Removal shifts every entry from the removed place onwards one step to the old end.
   always_comb begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         cells_in[j] = cells_ff[j];
      end
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
         if (remove_en && (IDX_W'(j) >= remove_pos)) cells_in[j] = cells_ff[j + 1];
      end
      if (push_en) cells_in[count_ff[IDX_W-1:0]] = tag_ff;
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         cells_ff[j] <= cells_in[j];
      end
      found_ff     <= found_in;
      dropped_ff   <= dropped_in;
      underflow_ff <= underflow_in;
      if (cmd.load) begin
         kind_ff <= req_kind;
         tag_ff  <= req_tag;
      end
      if (cmd.dispatch) begin
         rsp_dispatch_valid_ff <= disp_ok;
         rsp_dispatch_tag_ff   <= disp_ok ? cells_ff[0] : '0;
         rsp_cancel_found_ff   <= found_ff;
         rsp_push_dropped_ff   <= dropped_ff;
         rsp_done_underflow_ff <= underflow_ff;
         rsp_queued_count_ff   <= count_in;
         rsp_running_count_ff  <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         running_ff     <= '0;
         max_workers_ff <= MAX_WORKERS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         running_ff <= running_in;
         if (csr_write) max_workers_ff <= csr_data;
         if (cmd.dispatch) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dispatch_valid = rsp_dispatch_valid_ff;
   assign rsp_dispatch_tag   = rsp_dispatch_tag_ff;
   assign rsp_cancel_found   = rsp_cancel_found_ff;
   assign rsp_push_dropped   = rsp_push_dropped_ff;
   assign rsp_done_underflow = rsp_done_underflow_ff;
   assign rsp_queued_count   = rsp_queued_count_ff;
   assign rsp_running_count  = rsp_running_count_ff;
   assign status.out_full    = rsp_valid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_cancel_found, rsp_push_dropped, rsp_done_underflow}))
      else $error("more than one event flag in a result");

   a_dispatch_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dispatch_valid) |-> (rsp_running_count != '0))
      else $error("dispatch reported with no running job");

endmodule

### sv/concurrency_limited_job_queue_unit.sv
// Top level of the concurrency-limited job queue.
// Event items arrive on req_ch: kind 0 pushes job_tag at the young end of the
// queue, kind 1 frees one running slot, kind 2 cancels the youngest waiting
// entry equal to job_tag. After each event the oldest waiting job is started
// if fewer than max_workers jobs run. Each event gives exactly one result item
// on rsp_ch with the dispatch, the event flags and both counts.
// csr_ch writes max_workers; it is always ready. The user must write it only
// while idle; the block itself does not enforce this. An item passes through
// accept, event execution against the shift-chain queue, then the dispatch
// step that loads the result register. The next item is accepted in the cycle
// after that, so no new item is taken before the last one is dispatched; the
// result is registered by the dispatch step. If rsp_ch stalls, a finished
// result waits in the result register while the next item is accepted and
// executed; that item then waits in its dispatch step until the register is
// free, and req_ch holds ready low.
// Synchronous reset empties the queue, clears the running count and sets
// max_workers to 4.
module concurrency_limited_job_queue_unit
   import cljq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int TAG_BITS    = DEF_TAG_BITS
)
(
   input logic      clock,
   input logic      reset,
   cljq_req_if.sink   req_ch,
   cljq_rsp_if.source rsp_ch,
   cljq_csr_if.sink   csr_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ch.ready = 1'b1;

   cljq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cljq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_ch.kind),
      .req_tag            (req_ch.job_tag),
      .csr_write          (csr_ch.valid),
      .csr_data           (csr_ch.max_workers),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_dispatch_valid (rsp_ch.dispatch_valid),
      .rsp_dispatch_tag   (rsp_ch.dispatch_tag),
      .rsp_cancel_found   (rsp_ch.cancel_found),
      .rsp_push_dropped   (rsp_ch.push_dropped),
      .rsp_done_underflow (rsp_ch.done_underflow),
      .rsp_queued_count   (rsp_ch.queued_count),
      .rsp_running_count  (rsp_ch.running_count)
   );

endmodule
